### design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock, off during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ifcg_pkg.sv
// Types and constants of the ideal FIR coefficient generator.
package ifcg_pkg;

    localparam int unsigned MAX_TAPS       = 128;
    localparam int unsigned COEF_FRAC_BITS = 16;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF      = 2'd2;

    localparam int unsigned AD_W  = 7;
    localparam int unsigned W_W   = 18;
    localparam int unsigned ANG_W = 25;
    localparam int unsigned PH_W  = 32;
    localparam int unsigned DEN_W = 37;
    localparam int unsigned NUM_W = 47;
    localparam int unsigned Q_W   = 17;
    localparam int unsigned SIN_W = 32;

    localparam int unsigned SIN_LAT = 8;

    localparam logic [7:0]  TAP_LIMIT    = 8'(MAX_TAPS);
    localparam logic [29:0] PI_Q28       = 30'd843314857;
    localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

    typedef logic [30:0] sin_coef_arr_t [6];
    localparam sin_coef_arr_t SIN_COEF = '{
        31'd1686629713, 31'd693598668, 31'd85569306,
        31'd5026995, 31'd172272, 31'd3864
    };

    typedef enum logic [1:0] {
        FT_LOWPASS  = 2'd0,
        FT_HIGHPASS = 2'd1,
        FT_BANDPASS = 2'd2,
        FT_BANDSTOP = 2'd3
    } ftype_t;

    typedef struct packed {
        logic valid;
        logic bad;
        logic center;
        logic neg;
        logic comp;
    } tag_t;

endpackage

### design/ifcg_sine.sv
// Pipelined sine of a 32-bit turn phase, Q30 result, polynomial by Horner.
module ifcg_sine (
    input  logic                             clk,
    input  logic                             en,
    input  logic [ifcg_pkg::PH_W-1:0]        phase,
    output logic signed [ifcg_pkg::SIN_W-1:0] sine
);
    import ifcg_pkg::*;

    logic [30:0] x_reg    [0:6];
    logic [1:0]  quad_reg [0:6];
    logic [30:0] y_reg    [1:6];
    logic [30:0] r_reg    [2:6];
    logic [30:0] r_next   [2:6];
    logic signed [SIN_W-1:0] sine_reg;

    logic [30:0] x_fold;
    logic [61:0] sq;
    logic [61:0] fin_prod;
    logic [31:0] s_raw;
    logic [31:0] s_clamp;

    // fold to a quarter turn
    assign x_fold = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    assign sq     = 62'(x_reg[0]) * 62'(x_reg[0]);

    genvar s;
    generate
        for (s = 2; s <= 6; s++) begin : g_horner
            logic [30:0] r_src;
            logic [61:0] prod;
            if (s == 2) begin : g_first
                assign r_src = SIN_COEF[5];
            end else begin : g_rest
                assign r_src = r_reg[s-1];
            end
            assign prod      = 62'(r_src) * 62'(y_reg[s-1]);
            assign r_next[s] = 31'(32'(SIN_COEF[6-s]) - prod[61:30]);
        end
    endgenerate

    assign fin_prod = 62'(r_reg[6]) * 62'(x_reg[6]);
    assign s_raw    = fin_prod[61:30];
    assign s_clamp  = (s_raw > 32'(Q30_ONE)) ? 32'(Q30_ONE) : s_raw;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_fold;
            quad_reg[0] <= phase[31:30];
            x_reg[1]    <= x_reg[0];
            quad_reg[1] <= quad_reg[0];
            y_reg[1]    <= sq[60:30];
            for (int k = 2; k <= 6; k++)
            begin
                x_reg[k]    <= x_reg[k-1];
                quad_reg[k] <= quad_reg[k-1];
                y_reg[k]    <= y_reg[k-1];
                r_reg[k]    <= r_next[k];
            end
            sine_reg <= quad_reg[6][1] ? -$signed(s_clamp) : $signed(s_clamp);
        end
    end

    assign sine = sine_reg;

endmodule

### design/ifcg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag line.
`include "assert_macros.svh"

module ifcg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [ifcg_pkg::NUM_W-1:0]  num,
    input  logic [ifcg_pkg::DEN_W-1:0]  den,
    input  ifcg_pkg::tag_t              tag_in,
    output logic [ifcg_pkg::Q_W-1:0]    quot,
    output ifcg_pkg::tag_t              tag_out
);
    import ifcg_pkg::*;

    localparam int unsigned CMP_W = DEN_W + Q_W;

    logic [NUM_W-1:0] rem_reg  [Q_W];
    logic [DEN_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   quot_reg [Q_W];
    tag_t             tag_reg  [Q_W];

    logic [NUM_W-1:0] rem_next  [Q_W];
    logic [Q_W-1:0]   quot_next [Q_W];

    genvar j;
    generate
        for (j = 0; j < Q_W; j++) begin : g_stage
            logic [NUM_W-1:0] rem_src;
            logic [DEN_W-1:0] den_src;
            logic [Q_W-1:0]   q_src;
            logic [CMP_W-1:0] dsh;
            logic             ge;
            if (j == 0) begin : g_head
                assign rem_src = num;
                assign den_src = den;
                assign q_src   = '0;
            end else begin : g_body
                assign rem_src = rem_reg[j-1];
                assign den_src = den_reg[j-1];
                assign q_src   = quot_reg[j-1];
            end
            assign dsh = CMP_W'(den_src) << (Q_W - 1 - j);
            assign ge  = CMP_W'(rem_src) >= dsh;
            assign rem_next[j] = ge ? (rem_src - dsh[NUM_W-1:0]) : rem_src;
            always_comb
            begin
                quot_next[j]            = q_src;
                quot_next[j][Q_W-1-j]   = ge;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int k = 1; k < Q_W; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                quot_reg[k] <= quot_next[k];
            end
            den_reg[0] <= den;
            for (int k = 1; k < Q_W; k++)
            begin
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quot    = quot_reg[Q_W-1];
    assign tag_out = tag_reg[Q_W-1];

    `ASSERT_CLK(a_div_rem_below_den, tag_reg[Q_W-1].valid && !tag_reg[Q_W-1].bad |-> rem_reg[Q_W-1] < NUM_W'(den_reg[Q_W-1]), "divider remainder not below divisor")

endmodule

### design/ideal_fir_coefficient_generator.sv
// Top level of the ideal FIR coefficient generator.
//
//  channel   signals                                   direction
//  config    cfg_we, cfg_index, cfg_data               in, write only
//  request   in_valid, in_ready, tap_index             in
//  result    out_valid, out_ready, coefficient,
//            index_bad                                 out
//
//  One request enters per cycle unless a result is waiting on out_ready; it passes stages A, B, C,
//  the 8-stage sine pipeline, stage D, the 17-stage divider and the output register.
//  Reset returns configuration to its defaults and clears all valid bits; no clearing pass.
//  A result waiting on out_ready freezes the whole pipeline and drops in_ready.
`include "assert_macros.svh"

module ideal_fir_coefficient_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ifcg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ifcg_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [6:0]                            tap_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [17:0]                    coefficient,
    output logic                                  index_bad
);
    import ifcg_pkg::*;

    ftype_t           filter_type_reg;
    logic [7:0]       tap_count_reg;
    logic [W_W-1:0]   cutoff_reg;

    logic             en;

    // stage A
    logic [7:0]        t_lim;
    logic signed [9:0] d_s;
    logic [9:0]        d_abs;
    tag_t              a_tag_next;
    tag_t              a_tag_reg;
    logic [AD_W-1:0]   a_ad_reg;

    // stage B
    tag_t              b_tag_reg;
    logic [ANG_W-1:0]  b_angle_reg;
    logic [DEN_W-1:0]  b_den_reg;

    // stage C
    logic [55:0]       prod_a;
    logic [55:0]       prod_b;
    logic [55:0]       rnd_a;
    logic [55:0]       rnd_b;
    tag_t              c_tag_reg;
    logic [PH_W-1:0]   c_pha_reg;
    logic [PH_W-1:0]   c_phb_reg;
    logic [DEN_W-1:0]  c_den_reg;

    // alongside the sine pipeline
    tag_t              dl_tag_reg [SIN_LAT];
    logic [DEN_W-1:0]  dl_den_reg [SIN_LAT];
    logic signed [SIN_W-1:0] sa;
    logic signed [SIN_W-1:0] sb;

    // stage D
    logic signed [32:0] diff;
    logic [32:0]        diff_abs;
    tag_t               d_tag_next;
    logic [NUM_W-1:0]   d_num_next;
    tag_t               d_tag_reg;
    logic [NUM_W-1:0]   d_num_reg;
    logic [DEN_W-1:0]   d_den_reg;

    // divider and output
    logic [Q_W-1:0]     quot;
    tag_t               q_tag;
    logic signed [18:0] v;
    logic signed [17:0] coef_sat;
    logic               out_valid_reg;
    logic signed [17:0] coefficient_reg;
    logic               index_bad_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_type_reg <= FT_LOWPASS;
            tap_count_reg   <= 8'd1;
            cutoff_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_TYPE: filter_type_reg <= ftype_t'(cfg_data[1:0]);
                REG_TAP_COUNT:   tap_count_reg   <= cfg_data[7:0];
                REG_CUTOFF:      cutoff_reg      <= cfg_data[W_W-1:0];
                default:         ;
            endcase
        end
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage A: offset from the midpoint, doubled
    always_comb
    begin
        t_lim = (tap_count_reg > TAP_LIMIT) ? TAP_LIMIT : tap_count_reg;
        d_s   = $signed({2'b00, tap_index, 1'b0}) - $signed({2'b00, t_lim}) + 10'sd1;
        d_abs = d_s[9] ? 10'(-d_s) : 10'(d_s);
        a_tag_next        = '0;
        a_tag_next.valid  = in_valid;
        a_tag_next.bad    = {1'b0, tap_index} >= t_lim;
        a_tag_next.center = (d_s == 10'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= '0;
            b_tag_reg <= '0;
            c_tag_reg <= '0;
            d_tag_reg <= '0;
            for (int k = 0; k < SIN_LAT; k++)
            begin
                dl_tag_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_tag_reg     <= a_tag_next;
            b_tag_reg     <= a_tag_reg;
            c_tag_reg     <= b_tag_reg;
            dl_tag_reg[0] <= c_tag_reg;
            for (int k = 1; k < SIN_LAT; k++)
            begin
                dl_tag_reg[k] <= dl_tag_reg[k-1];
            end
            d_tag_reg     <= d_tag_next;
            out_valid_reg <= q_tag.valid;
        end
    end

    // phase of m*w and 2*m*w, rounded to a 32-bit turn
    assign prod_a = 56'(b_angle_reg) * 56'(TURN_PER_RAD);
    assign prod_b = 56'({b_angle_reg, 1'b0}) * 56'(TURN_PER_RAD);
    assign rnd_a  = prod_a + 56'h1_0000;
    assign rnd_b  = prod_b + 56'h1_0000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ad_reg    <= d_abs[AD_W-1:0];
            b_angle_reg <= ANG_W'(a_ad_reg) * ANG_W'(cutoff_reg);
            b_den_reg   <= a_tag_reg.center ? DEN_W'(PI_Q28)
                                            : DEN_W'(a_ad_reg) * DEN_W'(PI_Q28);
            c_pha_reg   <= rnd_a[48:17];
            c_phb_reg   <= rnd_b[48:17];
            c_den_reg   <= b_den_reg;
            dl_den_reg[0] <= c_den_reg;
            for (int k = 1; k < SIN_LAT; k++)
            begin
                dl_den_reg[k] <= dl_den_reg[k-1];
            end
            d_num_reg <= d_num_next;
            d_den_reg <= dl_den_reg[SIN_LAT-1];
        end
    end

    ifcg_sine u_sine_a (
        .clk   (clk),
        .en    (en),
        .phase (c_pha_reg),
        .sine  (sa)
    );

    ifcg_sine u_sine_b (
        .clk   (clk),
        .en    (en),
        .phase (c_phb_reg),
        .sine  (sb)
    );

    // stage D: sine difference and dividend
    always_comb
    begin
        case (filter_type_reg)
            FT_LOWPASS:  diff = 33'(sa);
            FT_HIGHPASS: diff = -33'(sa);
            FT_BANDPASS: diff = 33'(sb) - 33'(sa);
            default:     diff = 33'(sa) - 33'(sb);
        endcase
        diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
        d_tag_next      = dl_tag_reg[SIN_LAT-1];
        d_tag_next.neg  = diff[32] && !d_tag_next.center;
        d_tag_next.comp = d_tag_next.center &&
                          (filter_type_reg == FT_HIGHPASS || filter_type_reg == FT_BANDSTOP);
        if (d_tag_next.center)
        begin
            d_num_next = (NUM_W'(cutoff_reg) << (COEF_FRAC_BITS + 12))
                       + NUM_W'(PI_Q28 >> 1);
        end
        else
        begin
            d_num_next = (NUM_W'(diff_abs[31:0]) << (COEF_FRAC_BITS - 1))
                       + NUM_W'(dl_den_reg[SIN_LAT-1] >> 1);
        end
    end

    ifcg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (d_num_reg),
        .den     (d_den_reg),
        .tag_in  (d_tag_reg),
        .quot    (quot),
        .tag_out (q_tag)
    );

    // sign, complement for the high-pass and band-reject center, saturate
    always_comb
    begin
        if (q_tag.comp)
        begin
            v = (19'sd1 <<< COEF_FRAC_BITS) - $signed({2'b00, quot});
        end
        else if (q_tag.neg)
        begin
            v = -$signed({2'b00, quot});
        end
        else
        begin
            v = $signed({2'b00, quot});
        end
        if (v > 19'sd131071)
        begin
            coef_sat = 18'sd131071;
        end
        else if (v < -19'sd131072)
        begin
            coef_sat = -18'sd131072;
        end
        else
        begin
            coef_sat = 18'(v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coefficient_reg <= q_tag.bad ? 18'sd0 : coef_sat;
            index_bad_reg   <= q_tag.bad;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coefficient = coefficient_reg;
    assign index_bad   = index_bad_reg;

    `ASSERT_CLK(a_bad_gives_zero, out_valid_reg && index_bad_reg |-> coefficient_reg == 18'sd0, "flagged index with nonzero coefficient")
    `ASSERT_CLK(a_sine_in_range, dl_tag_reg[SIN_LAT-1].valid && !dl_tag_reg[SIN_LAT-1].bad |-> sa <= 32'sh4000_0000 && sa >= -32'sh4000_0000, "sine out of range")
    `ASSERT_NEXT(a_stall_holds_item, !en && d_tag_reg.valid, d_tag_reg.valid, "stalled item lost in pipeline")

endmodule
